[design/adc_voltage_morse_keyer_top_macros.svh]
// assertion macros for the morse keyer
`ifndef ADC_VOLTAGE_MORSE_KEYER_TOP_MACROS_SVH
`define ADC_VOLTAGE_MORSE_KEYER_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define AVMK_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AVMK_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/avmk_pkg.sv]
// shared types and constants for the morse keyer
`default_nettype none

package avmk_pkg;

    localparam int ADC_W   = 12;
    localparam int UNIT_W  = 16;
    localparam int TICKS_W = 19;

    localparam logic [ADC_W-1:0] LIMIT_0P5 = 12'd620;
    localparam logic [ADC_W-1:0] LIMIT_1P0 = 12'd1240;
    localparam logic [ADC_W-1:0] LIMIT_1P5 = 12'd1861;
    localparam logic [ADC_W-1:0] LIMIT_2P0 = 12'd2481;
    localparam logic [ADC_W-1:0] LIMIT_2P5 = 12'd3102;
    localparam logic [ADC_W-1:0] LIMIT_3P0 = 12'd3722;

    localparam logic [3:0] DIGIT_LAST = 4'd9;
    localparam logic [3:0] POINT_LAST = 4'd3;
    localparam logic [2:0] MARK_LAST  = 3'd4;

    typedef struct packed {
        logic       zero;
        logic [1:0] whole;
        logic [2:0] frac;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WHOLE,
        PH_POINT,
        PH_FRAC,
        PH_SPACE
    } phase_t;

    typedef enum logic [1:0] {
        UNITS_1,
        UNITS_3,
        UNITS_7
    } units_t;

endpackage

`default_nettype wire

[design/avmk_front.sv]
// front end: classifies a sample into its voltage digits and queues the word
`default_nettype none

module avmk_front (
    input  wire logic [avmk_pkg::ADC_W-1:0] adc_sample,
    input  wire logic                       start,
    input  wire logic                       full,
    output      logic                       push,
    output      avmk_pkg::cmd_t             cmd
);
    import avmk_pkg::*;

    always_comb
    begin
        cmd.zero = (adc_sample == '0);
        if (adc_sample == '0)
        begin
            cmd.whole = 2'd0;
            cmd.frac  = 3'd0;
        end
        else if (adc_sample <= LIMIT_0P5)
        begin
            cmd.whole = 2'd0;
            cmd.frac  = 3'd5;
        end
        else if (adc_sample <= LIMIT_1P0)
        begin
            cmd.whole = 2'd1;
            cmd.frac  = 3'd0;
        end
        else if (adc_sample <= LIMIT_1P5)
        begin
            cmd.whole = 2'd1;
            cmd.frac  = 3'd5;
        end
        else if (adc_sample <= LIMIT_2P0)
        begin
            cmd.whole = 2'd2;
            cmd.frac  = 3'd0;
        end
        else if (adc_sample <= LIMIT_2P5)
        begin
            cmd.whole = 2'd2;
            cmd.frac  = 3'd5;
        end
        else if (adc_sample <= LIMIT_3P0)
        begin
            cmd.whole = 2'd3;
            cmd.frac  = 3'd0;
        end
        else
        begin
            cmd.whole = 2'd3;
            cmd.frac  = 3'd3;
        end
    end

    assign push = start && !full;

endmodule

`default_nettype wire

[design/avmk_queue.sv]
// small word queue between front and back
`default_nettype none

module avmk_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire avmk_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output      avmk_pkg::cmd_t head_cmd,
    output      logic           empty,
    output      logic           full
);
    import avmk_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[design/avmk_back.sv]
// back end: sequences the morse periods of one word, one period per clock
`default_nettype none

module avmk_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [avmk_pkg::UNIT_W-1:0]  unit_length,
    input  wire avmk_pkg::cmd_t               head_cmd,
    input  wire logic                         empty,
    output      logic                         pop,
    output      logic                         out_valid,
    output      logic                         led_on,
    output      logic [avmk_pkg::TICKS_W-1:0] period_ticks,
    output      logic                         last_period
);
    import avmk_pkg::*;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [3:0]           cnt_reg;
    logic [3:0]           cnt_next;
    cmd_t                 cmd_reg;
    cmd_t                 cmd_next;
    logic                 valid_reg;
    logic                 led_reg;
    logic [TICKS_W-1:0]   ticks_reg;
    logic                 last_reg;

    logic                 active;
    logic                 led_now;
    logic                 last_now;
    units_t               units_now;
    logic [2:0]           digit;
    logic [2:0]           mark_idx;
    logic [TICKS_W-1:0]   unit_ext;
    logic [TICKS_W-1:0]   ticks_now;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        pop        = 1'b0;
        case (phase_reg)
            PH_IDLE, PH_SPACE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head_cmd;
                    phase_next = PH_WHOLE;
                    cnt_next   = '0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_WHOLE:
            begin
                if (cnt_reg == DIGIT_LAST)
                begin
                    cnt_next   = '0;
                    phase_next = cmd_reg.zero ? PH_SPACE : PH_POINT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            PH_POINT:
            begin
                if (cnt_reg == POINT_LAST)
                begin
                    cnt_next   = '0;
                    phase_next = PH_FRAC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            PH_FRAC:
            begin
                if (cnt_reg == DIGIT_LAST)
                begin
                    cnt_next   = '0;
                    phase_next = PH_SPACE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // period outputs
    assign digit    = (phase_reg == PH_FRAC) ? cmd_reg.frac : {1'b0, cmd_reg.whole};
    assign mark_idx = cnt_reg[3:1];

    always_comb
    begin
        active    = 1'b1;
        led_now   = 1'b0;
        last_now  = 1'b0;
        units_now = UNITS_1;
        case (phase_reg)
            PH_WHOLE, PH_FRAC:
            begin
                led_now = !cnt_reg[0];
                if (!cnt_reg[0])
                begin
                    units_now = (mark_idx < digit) ? UNITS_1 : UNITS_3;
                end
                else
                begin
                    units_now = (mark_idx == MARK_LAST) ? UNITS_3 : UNITS_1;
                end
            end
            PH_POINT:
            begin
                led_now   = !cnt_reg[0];
                units_now = (cnt_reg[1:0] == 2'd2) ? UNITS_3 : UNITS_1;
            end
            PH_SPACE:
            begin
                units_now = UNITS_7;
                last_now  = 1'b1;
            end
            default:
            begin
                active = 1'b0;
            end
        endcase
    end

    assign unit_ext = (unit_length == '0) ? TICKS_W'(1) : TICKS_W'(unit_length);

    always_comb
    begin
        case (units_now)
            UNITS_3: ticks_now = (unit_ext << 1) + unit_ext;
            UNITS_7: ticks_now = (unit_ext << 3) - unit_ext;
            default: ticks_now = unit_ext;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            valid_reg <= active;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        led_reg   <= led_now;
        ticks_reg <= ticks_now;
        last_reg  <= last_now;
    end

    assign out_valid    = valid_reg;
    assign led_on       = led_reg;
    assign period_ticks = ticks_reg;
    assign last_period  = last_reg;

endmodule

`default_nettype wire

[design/adc_voltage_morse_keyer_top.sv]
// top level of the adc voltage morse keyer
// A sample taken on start (while busy is low) is keyed out as a run of
// LED periods on out_valid strobes, one period per clock: 25 periods for a
// nonzero sample, 11 for a zero sample, the last one flagged by last_period.
// The sequencer emits one period per clock and pops the next word while it
// keys the current word space; a word reaches it through the queue slot and
// then the phase and output registers. A queue of QUEUE_DEPTH words sits in
// front of the sequencer, and busy rises only when it is full. The receiver
// cannot stall: each strobed period must be taken in its cycle. The user must
// write unit_length through cfg_we/cfg_wdata only while the block is idle;
// it is not enforced by the block. A value of zero keys as one tick per unit.
`default_nettype none

`include "adc_voltage_morse_keyer_top_macros.svh"

module adc_voltage_morse_keyer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic [avmk_pkg::ADC_W-1:0]   adc_sample,
    input  wire logic                         cfg_we,
    input  wire logic [avmk_pkg::UNIT_W-1:0]  cfg_wdata,
    output      logic                         out_valid,
    output      logic                         led_on,
    output      logic [avmk_pkg::TICKS_W-1:0] period_ticks,
    output      logic                         last_period
);
    import avmk_pkg::*;

    logic [UNIT_W-1:0] unit_length_reg;
    logic [UNIT_W-1:0] unit_length_next;
    cmd_t              push_cmd;
    cmd_t              head_cmd;
    logic              push;
    logic              pop;
    logic              empty;
    logic              full;

    assign unit_length_next = cfg_we ? cfg_wdata : unit_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_length_reg <= UNIT_W'(1);
        end
        else
        begin
            unit_length_reg <= unit_length_next;
        end
    end

    avmk_front u_front (
        .adc_sample (adc_sample),
        .start      (start),
        .full       (full),
        .push       (push),
        .cmd        (push_cmd)
    );

    avmk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty),
        .full     (full)
    );

    avmk_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .unit_length  (unit_length_reg),
        .head_cmd     (head_cmd),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .led_on       (led_on),
        .period_ticks (period_ticks),
        .last_period  (last_period)
    );

    assign busy = full;

    `AVMK_ASSERT_IMPLY(a_ticks_nonzero, out_valid, period_ticks != '0, "zero-length period")
    `AVMK_ASSERT_IMPLY(a_last_is_gap, out_valid && last_period, !led_on, "word space lit")
    `AVMK_ASSERT_IMPLY(a_busy_needs_push, $rose(busy), $past(start), "busy rose without a word")

endmodule

`default_nettype wire

[test/tb_top.sv]
// testbench for the adc voltage morse keyer: sample words in, keyed led periods checked
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                         led;
        logic [avmk_pkg::TICKS_W-1:0] ticks;
        logic                         last;
    } period_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [avmk_pkg::ADC_W-1:0]   adc_sample = '0;
    logic                         cfg_we = 1'b0;
    logic [avmk_pkg::UNIT_W-1:0]  cfg_wdata = '0;
    logic                         out_valid;
    logic                         led_on;
    logic [avmk_pkg::TICKS_W-1:0] period_ticks;
    logic                         last_period;

    logic [avmk_pkg::ADC_W-1:0]   sample_queue[$];
    period_t                      expected_periods[$];
    logic [avmk_pkg::UNIT_W-1:0]  unit_model = 16'd1;
    logic                         steady_feed = 1'b0;
    int                           failures = 0;

    adc_voltage_morse_keyer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .adc_sample   (adc_sample),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .led_on       (led_on),
        .period_ticks (period_ticks),
        .last_period  (last_period)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void push_period(input logic led, input int units, input logic last,
                                        input logic [avmk_pkg::UNIT_W-1:0] unit);
        period_t p;
        int      ticks;
        ticks = units * ((unit == 0) ? 1 : int'(unit));
        p.led = led;
        p.ticks = ticks[avmk_pkg::TICKS_W-1:0];
        p.last = last;
        expected_periods.push_back(p);
    endfunction

    function automatic void key_digit(input int d, input logic [avmk_pkg::UNIT_W-1:0] unit);
        logic is_dot;
        for (int i = 0; i < 5; i++)
        begin
            is_dot = (d <= 5) ? (i < d) : (i >= d - 5);
            push_period(1'b1, is_dot ? 1 : 3, 1'b0, unit);
            push_period(1'b0, (i == 4) ? 3 : 1, 1'b0, unit);
        end
    endfunction

    function automatic void predict_keying(input logic [avmk_pkg::ADC_W-1:0] s,
                                           input logic [avmk_pkg::UNIT_W-1:0] unit);
        int whole;
        int frac;
        if (s == 0)
        begin
            key_digit(0, unit);
        end
        else
        begin
            if (s <= 620)
            begin
                whole = 0;
                frac = 5;
            end
            else if (s <= 1240)
            begin
                whole = 1;
                frac = 0;
            end
            else if (s <= 1861)
            begin
                whole = 1;
                frac = 5;
            end
            else if (s <= 2481)
            begin
                whole = 2;
                frac = 0;
            end
            else if (s <= 3102)
            begin
                whole = 2;
                frac = 5;
            end
            else if (s <= 3722)
            begin
                whole = 3;
                frac = 0;
            end
            else
            begin
                whole = 3;
                frac = 3;
            end
            key_digit(whole, unit);
            // decimal point as keyed: dot, gap, dash, gap
            push_period(1'b1, 1, 1'b0, unit);
            push_period(1'b0, 1, 1'b0, unit);
            push_period(1'b1, 3, 1'b0, unit);
            push_period(1'b0, 1, 1'b0, unit);
            key_digit(frac, unit);
        end
        push_period(1'b0, 7, 1'b1, unit);
    endfunction

    // sample word driver
    always @(posedge clk)
    begin
        logic take;
        logic idle_now;
        if (rst_n)
        begin
            take = start && !busy;
            if (take)
                predict_keying(adc_sample, unit_model);
            idle_now = !steady_feed && ($urandom_range(0, 99) < 32);
            if (start && !take)
            begin
            end
            else if (sample_queue.size() != 0 && !idle_now)
            begin
                start <= 1'b1;
                adc_sample <= sample_queue.pop_front();
            end
            else
            begin
                start <= 1'b0;
                adc_sample <= 12'($urandom_range(0, 4095));
            end
        end
    end

    // period monitor
    always @(posedge clk)
    begin
        period_t got;
        period_t exp;
        if (rst_n && out_valid)
        begin
            got = '{led_on, period_ticks, last_period};
            if (expected_periods.size() == 0)
            begin
                failures++;
                if (failures < 50)
                    $display("%0t: unexpected period led=%0b ticks=%0d last=%0b",
                             $time, got.led, got.ticks, got.last);
            end
            else
            begin
                exp = expected_periods.pop_front();
                if (got !== exp)
                begin
                    failures++;
                    if (failures < 50)
                        $display({"%0t: expected led=%0b ticks=%0d last=%0b, ",
                                  "got led=%0b ticks=%0d last=%0b"},
                                 $time, exp.led, exp.ticks, exp.last,
                                 got.led, got.ticks, got.last);
                end
            end
        end
    end

    task automatic write_unit_length(input logic [avmk_pkg::UNIT_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        unit_model = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= 16'($urandom_range(0, 65535));
    endtask

    task automatic drain();
        while (sample_queue.size() != 0 || start || expected_periods.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int                          limits[6];
        logic [avmk_pkg::UNIT_W-1:0] units[6];
        int                          pick;
        limits = '{620, 1240, 1861, 2481, 3102, 3722};
        units = '{16'd0, 16'hFFFF, 16'd2, 16'd1, 16'($urandom_range(1, 65535)),
                  16'($urandom_range(3, 65535))};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: range ends, every step boundary, alternating bits
        write_unit_length(16'd1);
        @(negedge clk);
        sample_queue.push_back(12'd0);
        sample_queue.push_back(12'd4095);
        foreach (limits[i])
        begin
            sample_queue.push_back(12'(limits[i]));
            sample_queue.push_back(12'(limits[i] + 1));
        end
        sample_queue.push_back(12'd1);
        sample_queue.push_back(12'hAAA);
        sample_queue.push_back(12'h555);
        drain();

        foreach (units[ph])
        begin
            write_unit_length(units[ph]);
            steady_feed <= (ph == 2);
            @(negedge clk);
            for (int n = 0; n < 80; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    sample_queue.push_back(12'd0);
                else if (pick < 30)
                    sample_queue.push_back(12'(limits[$urandom_range(0, 5)]
                                               + $urandom_range(0, 1)));
                else
                    sample_queue.push_back(12'($urandom_range(0, 4095)));
            end
            drain();
        end

        steady_feed <= 1'b0;
        repeat (40) @(posedge clk);
        if (expected_periods.size() != 0)
        begin
            failures++;
            $display("%0t: %0d expected periods never arrived", $time, expected_periods.size());
        end
        if (failures == 0)
            $display("PASS adc_voltage_morse_keyer_top");
        else
            $display("FAIL adc_voltage_morse_keyer_top");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL adc_voltage_morse_keyer_top");
        $finish;
    end

endmodule

`default_nettype wire

[adc_voltage_morse_keyer_top.f]
+incdir+design
design/avmk_pkg.sv
design/avmk_front.sv
design/avmk_queue.sv
design/avmk_back.sv
design/adc_voltage_morse_keyer_top.sv
test/tb_top.sv
